// ===== hw/rtl/cap_pkg.sv =====
// Shared types, constants and the arctangent table of the Clifford attractor
// point generator. No dependencies; compiled first.
package cap_pkg;

   localparam int CAP_FRAC_BITS  = 16;
   localparam int CAP_COORD_BITS = 10;

   // CORDIC works in Q.30: angle register and vector register widths
   localparam int CAP_ZW      = 38;
   localparam int CAP_XW      = 33;
   localparam int CAP_STAGES  = 30;
   localparam int CAP_IDX_W   = 5;

   localparam logic signed [CAP_ZW-1:0] CAP_PI       = 38'sd3373259426;
   localparam logic signed [CAP_ZW-1:0] CAP_HALF_PI  = 38'sd1686629713;
   localparam logic signed [CAP_ZW-1:0] CAP_TWO_PI   = 38'sd6746518852;
   localparam logic signed [CAP_XW-1:0] CAP_GAIN     = 33'sd652032874;

   // configuration port
   localparam int CAP_CSR_IDX_W  = 3;
   localparam int CAP_CSR_DATA_W = 16;
   localparam logic [CAP_CSR_IDX_W-1:0] CSR_STEP_A = 3'd0;
   localparam logic [CAP_CSR_IDX_W-1:0] CSR_STEP_B = 3'd1;
   localparam logic [CAP_CSR_IDX_W-1:0] CSR_STEP_C = 3'd2;
   localparam logic [CAP_CSR_IDX_W-1:0] CSR_STEP_D = 3'd3;
   localparam logic [CAP_CSR_IDX_W-1:0] CSR_SCALE  = 3'd4;

   localparam logic [15:0] CAP_STEP_A_RST = 16'd1311;
   localparam logic [15:0] CAP_STEP_B_RST = 16'd655;
   localparam logic [15:0] CAP_STEP_C_RST = 16'd655;
   localparam logic [15:0] CAP_STEP_D_RST = 16'd655;
   localparam logic [7:0]  CAP_SCALE_RST  = 8'd120;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_SIN,
      ST_GO_SIN,
      ST_WAIT_SIN,
      ST_MUL_COS,
      ST_GO_COS,
      ST_WAIT_COS,
      ST_MUL_CM,
      ST_SUM,
      ST_SCALE_X,
      ST_SCALE_Y,
      ST_EMIT
   } cap_state_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_REDUCE,
      CS_WRAP,
      CS_FOLD,
      CS_ROTATE,
      CS_DONE
   } cap_cordic_state_type;

   // atan(2^-i) in Q.30
   function automatic logic signed [CAP_ZW-1:0] cap_atan(input logic [CAP_IDX_W-1:0] idx);
      logic signed [CAP_ZW-1:0] r;
      case (idx)
         5'd0:  r = 38'sd843314856;
         5'd1:  r = 38'sd497837829;
         5'd2:  r = 38'sd263043836;
         5'd3:  r = 38'sd133525158;
         5'd4:  r = 38'sd67021686;
         5'd5:  r = 38'sd33543515;
         5'd6:  r = 38'sd16775850;
         5'd7:  r = 38'sd8388437;
         5'd8:  r = 38'sd4194282;
         5'd9:  r = 38'sd2097149;
         5'd10: r = 38'sd1048575;
         5'd11: r = 38'sd524287;
         5'd12: r = 38'sd262143;
         5'd13: r = 38'sd131071;
         5'd14: r = 38'sd65535;
         5'd15: r = 38'sd32767;
         5'd16: r = 38'sd16383;
         5'd17: r = 38'sd8191;
         5'd18: r = 38'sd4095;
         5'd19: r = 38'sd2047;
         5'd20: r = 38'sd1023;
         5'd21: r = 38'sd511;
         5'd22: r = 38'sd255;
         5'd23: r = 38'sd127;
         5'd24: r = 38'sd63;
         5'd25: r = 38'sd31;
         5'd26: r = 38'sd15;
         5'd27: r = 38'sd7;
         5'd28: r = 38'sd3;
         5'd29: r = 38'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/cap_if.sv =====
// Valid/ready channel interfaces: request (new_frame) and response (point).
// Depends on cap_pkg for the default coordinate width.
interface cap_req_if;
   logic valid;
   logic ready;
   logic new_frame;

   modport source (output valid, output new_frame, input ready);
   modport sink   (input valid, input new_frame, output ready);
endinterface

interface cap_rsp_if #(parameter int COORD_BITS = cap_pkg::CAP_COORD_BITS);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic                         frame_start;

   modport source (output valid, output point_x, output point_y, output frame_start,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input frame_start,
                   output ready);
endinterface

// ===== hw/rtl/cap_coef.sv =====
// One bouncing coefficient: steps up or down per frame, flips direction at bounds.
// Depends on cap_pkg.
module cap_coef #(
   parameter int FRAC_BITS = cap_pkg::CAP_FRAC_BITS,
   parameter int INT_BITS  = 3,
   parameter int UPPER     = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          update,
   input  logic [15:0]                   step,
   output logic [INT_BITS+FRAC_BITS-1:0] coef
);
   import cap_pkg::*;

   localparam int W = INT_BITS + FRAC_BITS;
   localparam logic [W-1:0] ONE_F   = W'(1) << FRAC_BITS;
   localparam logic [W-1:0] UPPER_F = W'(UPPER) << FRAC_BITS;

   logic [W-1:0]           coef_ff, coef_in;
   logic                   down_ff, down_in;
   logic [FRAC_BITS+15:0]  step_wide;
   logic [FRAC_BITS-1:0]   step_f;
   logic signed [W+1:0]    sum;

   // step is Q0.16; rescale to Q.F, truncating
   assign step_wide = {step, {FRAC_BITS{1'b0}}};
   assign step_f    = step_wide[FRAC_BITS+15:16];

   always_comb begin
      if (down_ff) begin
         sum = $signed({2'b00, coef_ff}) - $signed({{(W+2-FRAC_BITS){1'b0}}, step_f});
      end else begin
         sum = $signed({2'b00, coef_ff}) + $signed({{(W+2-FRAC_BITS){1'b0}}, step_f});
      end
      coef_in = coef_ff;
      down_in = down_ff;
      if (update) begin
         if (sum[W+1]) begin
            coef_in = '0;
         end else if (sum[W]) begin
            coef_in = '1;
         end else begin
            coef_in = sum[W-1:0];
         end
         if (coef_in <= ONE_F || coef_in >= UPPER_F) begin
            down_in = ~down_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= ONE_F;
         down_ff <= 1'b0;
      end else begin
         coef_ff <= coef_in;
         down_ff <= down_in;
      end
   end

   assign coef = coef_ff;

endmodule

// ===== hw/rtl/cap_cordic.sv =====
// Iterative sine/cosine: range reduction by repeated subtraction or addition of
// two pi, then one CORDIC rotation step per cycle. Depends on cap_pkg.
module cap_cordic #(
   parameter int FRAC_BITS = cap_pkg::CAP_FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [FRAC_BITS+7:0] angle,
   output logic                        done,
   output logic signed [FRAC_BITS+3:0] sin_out,
   output logic signed [FRAC_BITS+3:0] cos_out
);
   import cap_pkg::*;

   localparam int SHIFT = 30 - FRAC_BITS;
   localparam logic signed [CAP_ZW-1:0] NEG_TWO_PI  = -CAP_TWO_PI;
   localparam logic signed [CAP_ZW-1:0] NEG_PI      = -CAP_PI;
   localparam logic signed [CAP_ZW-1:0] NEG_HALF_PI = -CAP_HALF_PI;

   cap_cordic_state_type state_ff, state_in;
   logic signed [CAP_ZW-1:0] z_ff, z_in;
   logic signed [CAP_XW-1:0] x_ff, x_in, y_ff, y_in;
   logic [CAP_IDX_W-1:0]     idx_ff, idx_in;
   logic                     neg_ff, neg_in;
   logic signed [CAP_XW-1:0] xs, ys, xn, yn, xq, yq;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (start) begin
               state_in = CS_REDUCE;
            end
         end
         CS_REDUCE: begin
            if (!(z_ff >= CAP_TWO_PI || z_ff <= NEG_TWO_PI)) begin
               state_in = CS_WRAP;
            end
         end
         CS_WRAP:   state_in = CS_FOLD;
         CS_FOLD:   state_in = CS_ROTATE;
         CS_ROTATE: begin
            if (idx_ff == CAP_IDX_W'(CAP_STAGES - 1)) begin
               state_in = CS_DONE;
            end
         end
         CS_DONE:   state_in = CS_IDLE;
         default:   state_in = CS_IDLE;
      endcase
   end

   // datapath
   assign xs = x_ff >>> idx_ff;
   assign ys = y_ff >>> idx_ff;

   always_comb begin
      z_in   = z_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      idx_in = idx_ff;
      neg_in = neg_ff;
      case (state_ff)
         CS_IDLE: begin
            z_in   = {angle, {SHIFT{1'b0}}};
            x_in   = CAP_GAIN;
            y_in   = '0;
            idx_in = '0;
            neg_in = 1'b0;
         end
         CS_REDUCE: begin
            if (z_ff >= CAP_TWO_PI) begin
               z_in = z_ff - CAP_TWO_PI;
            end else if (z_ff <= NEG_TWO_PI) begin
               z_in = z_ff + CAP_TWO_PI;
            end
         end
         CS_WRAP: begin
            if (z_ff > CAP_PI) begin
               z_in = z_ff - CAP_TWO_PI;
            end else if (z_ff < NEG_PI) begin
               z_in = z_ff + CAP_TWO_PI;
            end
         end
         CS_FOLD: begin
            if (z_ff > CAP_HALF_PI) begin
               z_in   = z_ff - CAP_PI;
               neg_in = 1'b1;
            end else if (z_ff < NEG_HALF_PI) begin
               z_in   = z_ff + CAP_PI;
               neg_in = 1'b1;
            end
         end
         CS_ROTATE: begin
            if (z_ff >= 0) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - cap_atan(idx_ff);
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + cap_atan(idx_ff);
            end
            idx_in = idx_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff   <= z_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      idx_ff <= idx_in;
      neg_ff <= neg_in;
   end

   // outputs: negate for folded angles, floor back to Q.F
   assign xn = neg_ff ? -x_ff : x_ff;
   assign yn = neg_ff ? -y_ff : y_ff;
   assign xq = xn >>> SHIFT;
   assign yq = yn >>> SHIFT;

   always_comb begin
      done = (state_ff == CS_DONE);
   end

   assign sin_out = yq[FRAC_BITS+3:0];
   assign cos_out = xq[FRAC_BITS+3:0];

endmodule

// ===== hw/rtl/clifford_attractor_point_generator_unit.sv =====
// Top level of the Clifford attractor point generator: configuration registers,
// sequencer, shared multiplier, output register. Depends on cap_pkg, cap_if,
// cap_coef and cap_cordic.
//
//   channel   direction  handshake            payload
//   req_chan  in         valid/ready          new_frame
//   rsp_chan  out        valid/ready          point_x, point_y, frame_start
//   csr_*     in         csr_write_enable     csr_index, csr_write_data
//
// Sequence: one request occupies the unit from the idle state that takes it
// until its point is handed over. Four sine/cosine evaluations run back to
// back on the one CORDIC unit (angle reduction, then 30 rotation steps and a
// done state each), with the shared multiplier between.
// Reset: synchronous; coefficients and position return to 1.0, steps and scale
// to their defaults. A finished point waits in the output register while the
// next request is taken; the sequencer holds before its result only if that
// register is still full.
module clifford_attractor_point_generator_unit #(
   parameter int FRAC_BITS  = cap_pkg::CAP_FRAC_BITS,
   parameter int COORD_BITS = cap_pkg::CAP_COORD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   cap_req_if.sink                             req_chan,
   cap_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [cap_pkg::CAP_CSR_IDX_W-1:0]   csr_index,
   input  logic [cap_pkg::CAP_CSR_DATA_W-1:0]  csr_write_data
);
   import cap_pkg::*;

   localparam int PW = FRAC_BITS + 4;   // position / multiplier operand
   localparam int MW = 2 * PW;          // product
   localparam int AW = FRAC_BITS + 8;   // product floored back to Q.F
   localparam int SW = FRAC_BITS + 9;   // sum of the map terms
   localparam logic signed [PW-1:0] ONE_POS = PW'(1) << FRAC_BITS;

   // configuration registers
   logic [15:0] step_a_ff, step_b_ff, step_c_ff, step_d_ff;
   logic [7:0]  scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_a_ff <= CAP_STEP_A_RST;
         step_b_ff <= CAP_STEP_B_RST;
         step_c_ff <= CAP_STEP_C_RST;
         step_d_ff <= CAP_STEP_D_RST;
         scale_ff  <= CAP_SCALE_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_STEP_A: step_a_ff <= csr_write_data;
            CSR_STEP_B: step_b_ff <= csr_write_data;
            CSR_STEP_C: step_c_ff <= csr_write_data;
            CSR_STEP_D: step_d_ff <= csr_write_data;
            CSR_SCALE:  scale_ff  <= csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer and datapath registers
   cap_state_type            state_ff, state_in;
   logic                     term_ff, term_in;
   logic                     nf_ff;
   logic signed [PW-1:0]     pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, nx_ff, nx_in;
   logic signed [PW-1:0]     s1_ff, c2_ff;
   logic signed [MW-1:0]     prod_ff;
   logic signed [COORD_BITS-1:0] out_x_ff;
   logic                     rsp_valid_ff;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic                     rsp_fs_ff;

   logic                     req_ready;
   logic                     accept;
   logic                     frame_update;
   logic                     mult_en;
   logic                     cordic_start;
   logic                     cordic_done;
   logic signed [PW-1:0]     cordic_sin, cordic_cos;
   logic signed [PW-1:0]     op_a, op_b;
   logic signed [MW-1:0]     prod_shift;
   logic signed [AW-1:0]     prod_f;
   logic signed [SW-1:0]     term_sum;
   logic signed [PW-1:0]     term_sat;
   logic signed [COORD_BITS-1:0] coord_sat;
   logic                     emit_free;

   logic [FRAC_BITS+2:0] coef_a, coef_b;
   logic [FRAC_BITS+1:0] coef_c, coef_d;

   assign accept       = req_chan.valid && req_ready;
   assign frame_update = accept && req_chan.new_frame;
   assign emit_free    = !rsp_valid_ff || rsp_chan.ready;

   cap_coef #(.FRAC_BITS(FRAC_BITS), .INT_BITS(3), .UPPER(4)) u_coef_a (
      .clock(clock), .reset(reset), .update(frame_update), .step(step_a_ff), .coef(coef_a));
   cap_coef #(.FRAC_BITS(FRAC_BITS), .INT_BITS(3), .UPPER(4)) u_coef_b (
      .clock(clock), .reset(reset), .update(frame_update), .step(step_b_ff), .coef(coef_b));
   cap_coef #(.FRAC_BITS(FRAC_BITS), .INT_BITS(2), .UPPER(3)) u_coef_c (
      .clock(clock), .reset(reset), .update(frame_update), .step(step_c_ff), .coef(coef_c));
   cap_coef #(.FRAC_BITS(FRAC_BITS), .INT_BITS(2), .UPPER(3)) u_coef_d (
      .clock(clock), .reset(reset), .update(frame_update), .step(step_d_ff), .coef(coef_d));

   // floor(product / 2^F)
   assign prod_shift = prod_ff >>> FRAC_BITS;
   assign prod_f     = prod_shift[AW-1:0];

   cap_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .angle  (prod_f),
      .done   (cordic_done),
      .sin_out(cordic_sin),
      .cos_out(cordic_cos)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL_SIN;
            end
         end
         ST_MUL_SIN:  state_in = ST_GO_SIN;
         ST_GO_SIN:   state_in = ST_WAIT_SIN;
         ST_WAIT_SIN: begin
            if (cordic_done) begin
               state_in = ST_MUL_COS;
            end
         end
         ST_MUL_COS:  state_in = ST_GO_COS;
         ST_GO_COS:   state_in = ST_WAIT_COS;
         ST_WAIT_COS: begin
            if (cordic_done) begin
               state_in = ST_MUL_CM;
            end
         end
         ST_MUL_CM:   state_in = ST_SUM;
         ST_SUM:      state_in = term_ff ? ST_SCALE_X : ST_MUL_SIN;
         ST_SCALE_X:  state_in = ST_SCALE_Y;
         ST_SCALE_Y:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake, multiplier operands, CORDIC start
   always_comb begin
      req_ready    = 1'b0;
      mult_en      = 1'b0;
      cordic_start = 1'b0;
      op_a         = '0;
      op_b         = '0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_MUL_SIN: begin
            mult_en = 1'b1;
            op_a    = term_ff ? $signed({1'b0, coef_b}) : $signed({1'b0, coef_a});
            op_b    = term_ff ? pos_x_ff : pos_y_ff;
         end
         ST_MUL_COS: begin
            mult_en = 1'b1;
            op_a    = term_ff ? $signed({1'b0, coef_b}) : $signed({1'b0, coef_a});
            op_b    = term_ff ? pos_y_ff : pos_x_ff;
         end
         ST_MUL_CM: begin
            mult_en = 1'b1;
            op_a    = term_ff ? $signed({2'b00, coef_d}) : $signed({2'b00, coef_c});
            op_b    = c2_ff;
         end
         ST_SCALE_X: begin
            mult_en = 1'b1;
            op_a    = $signed({{(PW-8){1'b0}}, scale_ff});
            op_b    = pos_x_ff;
         end
         ST_SCALE_Y: begin
            mult_en = 1'b1;
            op_a    = $signed({{(PW-8){1'b0}}, scale_ff});
            op_b    = pos_y_ff;
         end
         ST_GO_SIN: cordic_start = 1'b1;
         ST_GO_COS: cordic_start = 1'b1;
         default: begin
         end
      endcase
   end

   // new coordinate: sine term plus scaled cosine, saturated to signed Q3.F
   assign term_sum = $signed({{(SW-PW){s1_ff[PW-1]}}, s1_ff}) +
                     $signed({prod_f[AW-1], prod_f});

   always_comb begin
      if ((&term_sum[SW-1:PW-1]) || !(|term_sum[SW-1:PW-1])) begin
         term_sat = term_sum[PW-1:0];
      end else if (term_sum[SW-1]) begin
         term_sat = {1'b1, {(PW-1){1'b0}}};
      end else begin
         term_sat = {1'b0, {(PW-1){1'b1}}};
      end
   end

   // scaled coordinate, saturated to the output range
   always_comb begin
      if ((&prod_f[AW-1:COORD_BITS-1]) || !(|prod_f[AW-1:COORD_BITS-1])) begin
         coord_sat = prod_f[COORD_BITS-1:0];
      end else if (prod_f[AW-1]) begin
         coord_sat = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         coord_sat = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
   end

   // position and term bookkeeping
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      nx_in    = nx_ff;
      term_in  = term_ff;
      if (frame_update) begin
         pos_x_in = ONE_POS;
         pos_y_in = ONE_POS;
      end
      if (accept) begin
         term_in = 1'b0;
      end
      if (state_ff == ST_SUM) begin
         if (term_ff) begin
            pos_x_in = nx_ff;
            pos_y_in = term_sat;
         end else begin
            nx_in   = term_sat;
            term_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= 1'b0;
         pos_x_ff     <= ONE_POS;
         pos_y_ff     <= ONE_POS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         // drop valid once taken, raise it when the sequencer hands a point over
         if (state_ff == ST_EMIT && emit_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      nx_ff <= nx_in;
      if (accept) begin
         nf_ff <= req_chan.new_frame;
      end
      if (mult_en) begin
         prod_ff <= op_a * op_b;
      end
      if (state_ff == ST_WAIT_SIN && cordic_done) begin
         s1_ff <= cordic_sin;
      end
      if (state_ff == ST_WAIT_COS && cordic_done) begin
         c2_ff <= cordic_cos;
      end
      if (state_ff == ST_SCALE_Y) begin
         out_x_ff <= coord_sat;
      end
      if (state_ff == ST_EMIT && emit_free) begin
         rsp_x_ff  <= out_x_ff;
         rsp_y_ff  <= coord_sat;
         rsp_fs_ff <= nf_ff;
      end
   end

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.point_x     = rsp_x_ff;
   assign rsp_chan.point_y     = rsp_y_ff;
   assign rsp_chan.frame_start = rsp_fs_ff;

endmodule
